FILE: rtl/mctq_pkg.sv
// Shared types, constants and helpers of the multi-class timer queue.
// No dependencies; the top level, controller, datapath and divider import this package.
`default_nettype none
package mctq_pkg;

	localparam int NUM_CLASSES  = 4;
	localparam int CLASS_DEPTH  = 16;
	localparam int TICKS_PER_MS = 1000;
	localparam int NUM_REGS     = 4;

	localparam int SLOTS    = NUM_CLASSES * CLASS_DEPTH;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HEAD_W   = $clog2(CLASS_DEPTH);
	localparam int FILL_W   = $clog2(CLASS_DEPTH + 1);
	localparam int CLS_W    = $clog2(NUM_CLASSES + 1);
	localparam int CIW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int TPM_W    = $clog2(TICKS_PER_MS + 1);
	localparam int PROD_W   = 31 + TPM_W;
	localparam int TO_W     = 27;
	localparam int TIME_W   = 63;
	localparam int HANDLE_W = 16;
	localparam int ENTRY_W  = TIME_W + HANDLE_W;

	localparam logic [63:0] MAX_DELAY_TICKS = 64'd1000000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_UPDATE = 2'd0,
		REQ_ATTACH = 2'd1,
		REQ_CHECK  = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KIND_NOW      = 3'd0,
		KIND_FIRED    = 3'd1,
		KIND_NONE     = 3'd2,
		KIND_WAIT     = 3'd3,
		KIND_REJECTED = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MUL, ST_UPD_ADD, ST_UPD_FIN, ST_EMIT_NOW,
		ST_ATT_DEC, ST_ATT_WR, ST_EMIT_REJ, ST_EMIT_FIRE,
		ST_CHK_SEL, ST_CHK_CMP, ST_CHK_END,
		ST_QRY_BASE, ST_QRY_SEL, ST_QRY_MIN, ST_QRY_DEC, ST_QRY_WAIT, ST_EMIT_ANS
	} state_t;

	typedef logic [NUM_REGS-1:0][TO_W-1:0] tmo_arr_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic upd_add;
		logic upd_fin;
		logic att_wr;
		logic emit_now;
		logic emit_rej;
		logic emit_fire;
		logic cls_clr;
		logic cls_inc;
		logic ram_rd;
		logic chk_pop;
		logic chk_end;
		logic qry_base;
		logic qry_min;
		logic div_start;
		logic emit_ans;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic to_zero;
		logic cls_done;
		logic fill_zero;
		logic head_exp;
		logic pop_ok;
		logic out_free;
		logic ex_gt_now;
		logic div_busy;
	} status_t;

	function automatic logic [SLOT_W-1:0] slot_addr(input int c, input int p);
		return SLOT_W'(c * CLASS_DEPTH + p);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/multi_class_timer_queue.sv
// Top level of the multi-class timer queue: timeout registers behind APB,
// controller and datapath. Depends on mctq_pkg, mctq_ctrl and mctq_dp.
//
//  Channel   Direction  Handshake                       Payload
//  request   in         req_valid / req_stall           req_type .. min_wait_ms
//  result    out        res_valid / res_stall           result_kind .. last
//  config    in         psel penable pwrite pready      paddr, pwdata, prdata
//
// A time update passes through the multiply and the wide add and compare steps,
// and an attach either fires at once, is rejected or is multiplied and stored.
// A check skips each empty class and reads the head of every other, again after
// each pop of an expired head; a query multiplies, takes the least head of all
// classes and divides by the tick rate when the answer is nonzero. Reset clears
// the clock and empties all classes at once. A stalled result holds the block
// until the beat is taken.
`default_nettype none
module multi_class_timer_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [62:0]        system_time,
	input  wire logic signed [31:0] max_wait_ms,
	input  wire logic               interrupted,
	input  wire logic [1:0]         timer_class,
	input  wire logic [15:0]        timer_handle,
	input  wire logic [62:0]        check_time,
	input  wire logic [30:0]        wait_ms,
	input  wire logic [30:0]        min_wait_ms,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic      [2:0]         result_kind,
	output logic      [15:0]        fired_handle,
	output logic      [62:0]        value,
	output logic      [6:0]         fire_count,
	output logic                    last
);
	import mctq_pkg::*;

	tmo_arr_t timeout_q;
	cmd_t     cmd;
	status_t  sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (psel && penable && pwrite) begin
			timeout_q[paddr[3:2]] <= pwdata[TO_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = 32'(timeout_q[paddr[3:2]]);

	mctq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_type),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mctq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.timeouts     (timeout_q),
		.req_type     (req_type),
		.system_time  (system_time),
		.max_wait_ms  (max_wait_ms),
		.interrupted  (interrupted),
		.timer_class  (timer_class),
		.timer_handle (timer_handle),
		.check_time   (check_time),
		.wait_ms      (wait_ms),
		.min_wait_ms  (min_wait_ms),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.result_kind  (result_kind),
		.fired_handle (fired_handle),
		.value        (value),
		.fire_count   (fire_count),
		.last         (last)
	);
endmodule
`default_nettype wire

FILE: rtl/mctq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module mctq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/mctq_div.sv
// Divider by the constant tick rate: four 16-bit chunks, each divided by a
// reciprocal multiplication followed by a remainder step. Depends on mctq_pkg.
`default_nettype none
module mctq_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mctq_pkg::TIME_W-1:0]  dividend,
	output logic                              busy,
	output logic      [mctq_pkg::TIME_W-1:0]  quotient
);
	import mctq_pkg::*;

	localparam int CH_W  = 16;
	localparam int NCH   = 4;
	localparam int DIV_W = CH_W * NCH;
	localparam int REM_W = TPM_W;
	localparam int CHK_W = REM_W + CH_W;
	localparam int SH    = CHK_W + REM_W;
	localparam int RCP_W = CHK_W + 2;
	localparam int PRD_W = CHK_W + RCP_W;
	localparam int CNT_W = 4;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(TICKS_PER_MS) - 64'd1) / 64'(TICKS_PER_MS);

	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [PRD_W-1:0] prod_q;
	logic [CHK_W-1:0] chunk;
	logic [CH_W-1:0]  qd;

	// The chunk is the running remainder followed by the next 16 dividend bits.
	assign chunk = {rem_q, quo_q[DIV_W-1 -: CH_W]};
	assign qd = prod_q[SH +: CH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(2 * NCH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {1'b0, dividend};
		end else if (cnt_q != '0) begin
			if (!cnt_q[0]) begin
				prod_q <= PRD_W'(chunk) * PRD_W'(RECIP[RCP_W-1:0]);
			end else begin
				rem_q <= REM_W'(chunk - CHK_W'(qd) * CHK_W'(TICKS_PER_MS));
				quo_q <= {quo_q[DIV_W-CH_W-1:0], qd};
			end
		end
	end

	assign busy = cnt_q != '0;
	assign quotient = quo_q[TIME_W-1:0];
endmodule
`default_nettype wire

FILE: rtl/mctq_ctrl.sv
// Controller state machine of the timer queue: sequences the datapath per request.
// Depends on mctq_pkg.
`default_nettype none
module mctq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic [1:0]         req_type,
	output logic                    req_stall,
	input  wire mctq_pkg::status_t  sts,
	output mctq_pkg::cmd_t          cmd
);
	import mctq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					cmd.cls_clr = 1'b1;
					case (req_t'(req_type))
						REQ_UPDATE: state_d = ST_MUL;
						REQ_ATTACH: state_d = ST_ATT_DEC;
						REQ_CHECK:  state_d = ST_CHK_SEL;
						REQ_QUERY:  state_d = ST_MUL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				case (sts.req)
					REQ_UPDATE: state_d = ST_UPD_ADD;
					REQ_ATTACH: state_d = ST_ATT_WR;
					default:    state_d = ST_QRY_BASE;
				endcase
			end
			ST_UPD_ADD: begin
				cmd.upd_add = 1'b1;
				state_d = ST_UPD_FIN;
			end
			ST_UPD_FIN: begin
				cmd.upd_fin = 1'b1;
				state_d = ST_EMIT_NOW;
			end
			ST_EMIT_NOW: begin
				if (sts.out_free) begin
					cmd.emit_now = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ATT_DEC: begin
				if (sts.full) begin
					state_d = ST_EMIT_REJ;
				end else if (sts.to_zero) begin
					state_d = ST_EMIT_FIRE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_ATT_WR: begin
				cmd.att_wr = 1'b1;
				state_d = ST_EMIT_NOW;
			end
			ST_EMIT_REJ: begin
				if (sts.out_free) begin
					cmd.emit_rej = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_FIRE: begin
				if (sts.out_free) begin
					cmd.emit_fire = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CHK_SEL: begin
				if (sts.cls_done) begin
					state_d = ST_CHK_END;
				end else if (sts.fill_zero) begin
					cmd.cls_inc = 1'b1;
				end else begin
					cmd.ram_rd = 1'b1;
					state_d = ST_CHK_CMP;
				end
			end
			ST_CHK_CMP: begin
				if (!sts.head_exp) begin
					cmd.cls_inc = 1'b1;
					state_d = ST_CHK_SEL;
				end else if (sts.pop_ok) begin
					cmd.chk_pop = 1'b1;
					state_d = ST_CHK_SEL;
				end
			end
			ST_CHK_END: begin
				if (sts.out_free) begin
					cmd.chk_end = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_QRY_BASE: begin
				cmd.qry_base = 1'b1;
				state_d = ST_QRY_SEL;
			end
			ST_QRY_SEL: begin
				if (sts.cls_done) begin
					state_d = ST_QRY_DEC;
				end else if (sts.fill_zero) begin
					cmd.cls_inc = 1'b1;
				end else begin
					cmd.ram_rd = 1'b1;
					state_d = ST_QRY_MIN;
				end
			end
			ST_QRY_MIN: begin
				cmd.qry_min = 1'b1;
				cmd.cls_inc = 1'b1;
				state_d = ST_QRY_SEL;
			end
			ST_QRY_DEC: begin
				if (sts.ex_gt_now) begin
					cmd.div_start = 1'b1;
					state_d = ST_QRY_WAIT;
				end else begin
					state_d = ST_EMIT_ANS;
				end
			end
			ST_QRY_WAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_EMIT_ANS;
				end
			end
			ST_EMIT_ANS: begin
				if (sts.out_free) begin
					cmd.emit_ans = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
endmodule
`default_nettype wire

FILE: rtl/mctq_dp.sv
// Datapath of the timer queue: clock correction, class FIFOs, result register.
// Depends on mctq_pkg, mctq_ram and mctq_div.
`default_nettype none
module mctq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mctq_pkg::cmd_t                cmd,
	output mctq_pkg::status_t                  sts,
	input  wire mctq_pkg::tmo_arr_t            timeouts,
	input  wire logic [1:0]                    req_type,
	input  wire logic [62:0]                   system_time,
	input  wire logic signed [31:0]            max_wait_ms,
	input  wire logic                          interrupted,
	input  wire logic [1:0]                    timer_class,
	input  wire logic [15:0]                   timer_handle,
	input  wire logic [62:0]                   check_time,
	input  wire logic [30:0]                   wait_ms,
	input  wire logic [30:0]                   min_wait_ms,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic      [2:0]                    result_kind,
	output logic      [15:0]                   fired_handle,
	output logic      [62:0]                   value,
	output logic      [6:0]                    fire_count,
	output logic                               last
);
	import mctq_pkg::*;

	req_t               req_q;
	logic [TIME_W-1:0]  sys_q;
	logic [31:0]        mw_q;
	logic               intr_q;
	logic [1:0]         tcls_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TIME_W-1:0]  t_q;
	logic [30:0]        wait_q;
	logic [30:0]        floor_q;

	logic [TIME_W-1:0]  now_q;
	logic [63:0]        offset_q;
	logic               primed_q;
	logic [PROD_W-1:0]  prod_q;
	logic [64:0]        sum_q;
	logic [63:0]        dl_q;
	logic [63:0]        ex_q;

	logic [HEAD_W-1:0]  head_q [NUM_CLASSES];
	logic [FILL_W-1:0]  fill_q [NUM_CLASSES];
	logic [CLS_W-1:0]   cls_q;
	logic               pend_valid_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	logic [TIME_W-1:0]  pend_value_q;
	logic [6:0]         cnt_q;

	logic               res_valid_q;
	logic [2:0]         kind_q;
	logic [HANDLE_W-1:0] rhandle_q;
	logic [TIME_W-1:0]  rvalue_q;
	logic [6:0]         rcount_q;
	logic               rlast_q;

	logic [CIW-1:0]     cidx;
	logic [CIW-1:0]     aidx;
	logic               cls_bad;
	logic [FILL_W:0]    pos_sum;
	logic [FILL_W:0]    pos;
	logic [HEAD_W-1:0]  head_next;
	logic [ENTRY_W-1:0] rdata;
	logic [TIME_W-1:0]  rd_exp;
	logic [HANDLE_W-1:0] rd_handle;
	logic [30:0]        mul_a;
	logic [63:0]        sat_sum;
	logic [TIME_W-1:0]  now_plus;
	logic [TIME_W-1:0]  nn;
	logic               back;
	logic               out_free;
	logic               emit_any;
	logic               div_busy;
	logic [TIME_W-1:0]  quotient;
	logic [63:0]        diff;
	logic [TIME_W-1:0]  ans;

	assign cidx = CIW'(cls_q);
	assign aidx = CIW'(tcls_q);
	assign cls_bad = (32'(tcls_q) >= NUM_CLASSES) || (32'(tcls_q) >= NUM_REGS);
	assign pos_sum = (FILL_W + 1)'(head_q[aidx]) + (FILL_W + 1)'(fill_q[aidx]);
	assign pos = (pos_sum >= (FILL_W + 1)'(CLASS_DEPTH)) ?
		pos_sum - (FILL_W + 1)'(CLASS_DEPTH) : pos_sum;
	assign head_next = (32'(head_q[cidx]) + 1 == CLASS_DEPTH) ? '0 : head_q[cidx] + 1'b1;
	assign rd_exp = rdata[TIME_W-1:0];
	assign rd_handle = rdata[ENTRY_W-1:TIME_W];

	always_comb begin
		case (req_q)
			REQ_UPDATE: mul_a = mw_q[30:0];
			REQ_ATTACH: mul_a = 31'(timeouts[tcls_q]);
			default:    mul_a = wait_q;
		endcase
	end

	assign sat_sum = {1'b0, now_q} + 64'(prod_q);
	assign now_plus = sat_sum[63] ? TIME_MAX : sat_sum[TIME_W-1:0];
	assign back = sum_q[64] || (sum_q[63:0] < {1'b0, now_q});
	assign nn = intr_q ? now_q : now_plus;
	assign diff = ex_q - {1'b0, now_q};
	assign ans = (quotient >= TIME_W'(floor_q)) ? quotient : TIME_W'(floor_q);

	assign out_free = !res_valid_q || !res_stall;
	assign emit_any = cmd.emit_now || cmd.emit_rej || cmd.emit_fire || cmd.emit_ans ||
		cmd.chk_end || (cmd.chk_pop && pend_valid_q);

	mctq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.att_wr),
		.waddr(slot_addr(int'(aidx), int'(pos))),
		.wdata({handle_q, now_plus}),
		.re   (cmd.ram_rd),
		.raddr(slot_addr(int'(cidx), int'(head_q[cidx]))),
		.rdata(rdata)
	);

	mctq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(diff[TIME_W-1:0]),
		.busy    (div_busy),
		.quotient(quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q    <= req_t'(req_type);
			sys_q    <= system_time;
			mw_q     <= max_wait_ms;
			intr_q   <= interrupted;
			tcls_q   <= timer_class;
			handle_q <= timer_handle;
			t_q      <= (check_time == '0) ? now_q : check_time;
			wait_q   <= wait_ms;
			floor_q  <= min_wait_ms;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(TICKS_PER_MS);
		end
		if (cmd.upd_add) begin
			sum_q <= {2'b00, sys_q} + {offset_q[63], offset_q};
			dl_q  <= {1'b0, now_q} + 64'(prod_q) + MAX_DELAY_TICKS;
		end
		if (cmd.qry_base) begin
			ex_q <= {1'b0, now_q} + 64'(prod_q);
		end else if (cmd.qry_min && ({1'b0, rd_exp} < ex_q)) begin
			ex_q <= {1'b0, rd_exp};
		end
		if (cmd.chk_pop) begin
			pend_handle_q <= rd_handle;
			pend_value_q  <= rd_exp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			offset_q <= '0;
			primed_q <= 1'b0;
		end else if (cmd.upd_fin) begin
			if (!primed_q || mw_q[31]) begin
				now_q    <= sys_q;
				offset_q <= '0;
				primed_q <= 1'b1;
			end else if (!back && (sum_q[63:0] < dl_q)) begin
				now_q <= sum_q[63] ? TIME_MAX : sum_q[TIME_W-1:0];
			end else begin
				now_q    <= nn;
				offset_q <= {1'b0, nn} - {1'b0, sys_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			cls_q        <= '0;
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cmd.att_wr) begin
				fill_q[aidx] <= fill_q[aidx] + 1'b1;
			end
			if (cmd.chk_pop) begin
				head_q[cidx] <= head_next;
				fill_q[cidx] <= fill_q[cidx] - 1'b1;
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			if (cmd.take) begin
				pend_valid_q <= 1'b0;
				cnt_q        <= '0;
			end
			if (cmd.cls_clr || cmd.qry_base) begin
				cls_q <= '0;
			end else if (cmd.cls_inc) begin
				cls_q <= cls_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_any) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_now || cmd.emit_rej) begin
			kind_q    <= cmd.emit_rej ? KIND_REJECTED : KIND_NOW;
			rhandle_q <= '0;
			rvalue_q  <= now_q;
			rcount_q  <= '0;
			rlast_q   <= 1'b1;
		end else if (cmd.emit_fire) begin
			kind_q    <= KIND_FIRED;
			rhandle_q <= handle_q;
			rvalue_q  <= now_q;
			rcount_q  <= 7'd1;
			rlast_q   <= 1'b1;
		end else if (cmd.emit_ans) begin
			kind_q    <= KIND_WAIT;
			rhandle_q <= '0;
			rvalue_q  <= (ex_q > {1'b0, now_q}) ? ans : '0;
			rcount_q  <= '0;
			rlast_q   <= 1'b1;
		end else if ((cmd.chk_pop && pend_valid_q) || (cmd.chk_end && pend_valid_q)) begin
			kind_q    <= KIND_FIRED;
			rhandle_q <= pend_handle_q;
			rvalue_q  <= pend_value_q;
			rcount_q  <= cnt_q;
			rlast_q   <= cmd.chk_end;
		end else if (cmd.chk_end) begin
			kind_q    <= KIND_NONE;
			rhandle_q <= '0;
			rvalue_q  <= '0;
			rcount_q  <= '0;
			rlast_q   <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign result_kind  = kind_q;
	assign fired_handle = rhandle_q;
	assign value        = rvalue_q;
	assign fire_count   = rcount_q;
	assign last         = rlast_q;

	always_comb begin
		sts           = '0;
		sts.req       = req_q;
		sts.full      = cls_bad || (32'(fill_q[aidx]) >= CLASS_DEPTH);
		sts.to_zero   = timeouts[tcls_q] == '0;
		sts.cls_done  = cls_q == CLS_W'(NUM_CLASSES);
		sts.fill_zero = fill_q[cidx] == '0;
		sts.head_exp  = rd_exp <= t_q;
		sts.pop_ok    = out_free || !pend_valid_q;
		sts.out_free  = out_free;
		sts.ex_gt_now = ex_q > {1'b0, now_q};
		sts.div_busy  = div_busy;
	end

	// A new result is only loaded when the result register can take it.
	assert property (@(posedge clk) disable iff (!arst_n) emit_any |-> out_free)
		else $error("result register overwritten while a beat is stalled");
	// A timer is only stored into a class that has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.att_wr |-> !cls_bad && (32'(fill_q[aidx]) < CLASS_DEPTH))
		else $error("store into a full class");
	// A pop only takes a nonempty class head that has expired.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chk_pop |-> (fill_q[cidx] != '0) && (rd_exp <= t_q))
		else $error("pop of an empty or unexpired class head");
	// The divider is started only when it is idle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");
endmodule
`default_nettype wire
